### rtl/cdv_pkg.sv
// Package for the check digit validator: scheme and status codes, character
// constants, per-scheme weights and the small remainder tables.
// No dependencies.
package cdv_pkg;

	localparam int unsigned MAX_LENGTH = 32;
	localparam int unsigned COUNT_W    = 6;
	localparam int unsigned LEN_W      = COUNT_W + 1;
	localparam int unsigned RES_W      = 4;
	localparam int unsigned PROD_W     = 7;
	localparam int unsigned LUT_DEPTH  = 1 << PROD_W;
	localparam int unsigned SUM_W      = 12;
	localparam int unsigned TOT_W      = SUM_W + 1;

	typedef enum logic [2:0] {
		SCH_LUHN    = 3'd0,
		SCH_IMEI    = 3'd1,
		SCH_USPS    = 3'd2,
		SCH_UPC     = 3'd3,
		SCH_ISBN10  = 3'd4,
		SCH_ISBN13  = 3'd5,
		SCH_ROUTING = 3'd6,
		SCH_ISSN    = 3'd7
	} scheme_t;

	typedef enum logic [2:0] {
		ST_NOT_VERIFIED = 3'd0,
		ST_VERIFIED     = 3'd1,
		ST_BAD_LENGTH   = 3'd2,
		ST_BAD_CHAR     = 3'd3,
		ST_CHECK_VALUE  = 3'd4
	} status_t;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_STAR    = 8'h2A;
	localparam logic [7:0] CHAR_X_UPPER = 8'h58;
	localparam logic [7:0] CHAR_X_LOWER = 8'h78;

	localparam logic [LEN_W-1:0] LEN_IMEI    = LEN_W'(15);
	localparam logic [LEN_W-1:0] LEN_USPS    = LEN_W'(11);
	localparam logic [LEN_W-1:0] LEN_UPC     = LEN_W'(12);
	localparam logic [LEN_W-1:0] LEN_ISBN10  = LEN_W'(10);
	localparam logic [LEN_W-1:0] LEN_ISBN13  = LEN_W'(13);
	localparam logic [LEN_W-1:0] LEN_ROUTING = LEN_W'(9);
	localparam logic [LEN_W-1:0] LEN_ISSN    = LEN_W'(8);
	localparam logic [LEN_W-1:0] LEN_MAX     = LEN_W'(MAX_LENGTH);
	localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

	localparam logic [RES_W-1:0] CHECK_X = 4'd10;

	// When a running total wraps past its width, its remainder drops by the
	// remainder of the wrap amount; these add back the complement.
	localparam logic [RES_W-1:0] WRAP9  = RES_W'(9 - (1 << SUM_W) % 9);
	localparam logic [RES_W-1:0] WRAP10 = RES_W'(10 - (1 << SUM_W) % 10);
	localparam logic [RES_W-1:0] WRAP11 = RES_W'(11 - (1 << SUM_W) % 11);

	typedef logic [RES_W-1:0] mod_lut_t [LUT_DEPTH];

	function automatic mod_lut_t build_mod9();
		mod_lut_t lut;
		for (int i = 0; i < LUT_DEPTH; i++) begin
			lut[i] = RES_W'(i % 9);
		end
		return lut;
	endfunction

	function automatic mod_lut_t build_mod10();
		mod_lut_t lut;
		for (int i = 0; i < LUT_DEPTH; i++) begin
			lut[i] = RES_W'(i % 10);
		end
		return lut;
	endfunction

	function automatic mod_lut_t build_mod11();
		mod_lut_t lut;
		for (int i = 0; i < LUT_DEPTH; i++) begin
			lut[i] = RES_W'(i % 11);
		end
		return lut;
	endfunction

	localparam mod_lut_t MOD9_LUT  = build_mod9();
	localparam mod_lut_t MOD10_LUT = build_mod10();
	localparam mod_lut_t MOD11_LUT = build_mod11();

	// Sum of two remainders below m, brought back below m.
	function automatic logic [RES_W-1:0] add_mod(logic [RES_W-1:0] a,
			logic [RES_W-1:0] b, logic [RES_W-1:0] m);
		logic [RES_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, m}) ? RES_W'(s - {1'b0, m}) : s[RES_W-1:0];
	endfunction

	// Weight of the leading digit at position p (0 is the leftmost digit).
	function automatic logic [3:0] weight_at(scheme_t s, logic [COUNT_W-1:0] p);
		logic [3:0] w;
		w = 4'd0;
		unique case (s)
			SCH_USPS:   w = 4'd1;
			SCH_UPC:    w = p[0] ? 4'd1 : 4'd3;
			SCH_ISBN10: w = (p < COUNT_W'(9)) ? p[3:0] + 4'd1 : 4'd0;
			SCH_ISBN13: w = p[0] ? 4'd3 : 4'd1;
			SCH_ROUTING: begin
				if (p < COUNT_W'(8)) begin
					unique case (p[2:0])
						3'd0, 3'd3, 3'd6: w = 4'd7;
						3'd1, 3'd4, 3'd7: w = 4'd3;
						default:          w = 4'd9;
					endcase
				end
			end
			SCH_ISSN:   w = (p < COUNT_W'(7)) ? 4'd8 - {1'b0, p[2:0]} : 4'd0;
			default:    w = 4'd0;
		endcase
		return w;
	endfunction

endpackage

### rtl/cdv_if.sv
// Handshake interfaces of the check digit validator: character words in,
// result words out and the scheme configuration write. No dependencies.
interface cdv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;
	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cdv_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] check_value;
	modport source (output valid, output status, output check_value, input ready);
	modport sink   (input valid, input status, input check_value, output ready);
endinterface

interface cdv_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] scheme_select;
	modport source (output valid, output scheme_select, input ready);
	modport sink   (input valid, input scheme_select, output ready);
endinterface

### rtl/check_digit_validator.sv
// Check digit validator top level: input register, running remainders and
// the result register. Depends on cdv_pkg and the interfaces in cdv_if.sv.
//
// Channel   Direction  Word
// cfg       in         scheme_select (3 bits)
// digits    in         char_code (8 bits), last_char (1 bit)
// verdict   out        status (3 bits), check_value (4 bits)
//
// A character word is taken every cycle unless a last character waits on a
// stalled result; its result passes the input and the result registers.
// Running sums are kept as remainders mod 9, 10 and 11 beside twelve-bit
// totals, whose wrap adjusts the remainders, one add each per word.
// Reset clears the scheme, the running state and both valid flags at once.
// Only a last character waits on a stalled result; others always pass.
module check_digit_validator (
	input  logic              clk,
	input  logic              arst_n,
	cdv_cfg_if.sink           cfg,
	cdv_char_if.sink          digits,
	cdv_result_if.source      verdict
);
	import cdv_pkg::*;

	scheme_t              scheme_q;
	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 last_s1;
	logic [COUNT_W-1:0]   count_q;
	logic [RES_W-1:0]     even_q;
	logic [RES_W-1:0]     odd_q;
	logic [RES_W-1:0]     w9_q;
	logic [RES_W-1:0]     w10_q;
	logic [RES_W-1:0]     w11_q;
	logic [SUM_W-1:0]     even_tot_q;
	logic [SUM_W-1:0]     odd_tot_q;
	logic [SUM_W-1:0]     wsum_q;
	logic                 bad_q;
	logic                 out_valid_q;
	status_t              status_q;
	logic [RES_W-1:0]     check_q;

	logic                 s1_adv;
	logic                 s1_fire;
	logic                 is_digit;
	logic [3:0]           d;
	logic [4:0]           d2;
	logic [3:0]           dbl;
	logic [3:0]           w;
	logic [7:0]           prod;
	logic [3:0]           even_term, odd_term;
	logic [TOT_W-1:0]     even_tot, odd_tot, wsum_tot;
	logic [RES_W-1:0]     even_nx, odd_nx, w9_nx, w10_nx, w11_nx;
	logic [RES_W-1:0]     luhn_r;
	logic [RES_W-1:0]     luhn_cv;
	logic [RES_W-1:0]     check;
	logic [LEN_W-1:0]     len;
	logic                 len_ok;
	logic                 xok;
	logic [RES_W-1:0]     given;
	status_t              status_nx;
	logic [RES_W-1:0]     value_nx;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q <= SCH_LUHN;
		end else if (cfg.valid) begin
			scheme_q <= scheme_t'(cfg.scheme_select);
		end
	end

	assign s1_adv       = !(last_s1 && out_valid_q && !verdict.ready);
	assign s1_fire      = valid_s1 && s1_adv;
	assign digits.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (digits.ready) begin
			valid_s1 <= digits.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (digits.ready && digits.valid) begin
			char_s1 <= digits.char_code;
			last_s1 <= digits.last_char;
		end
	end

	// Per-character terms.
	assign is_digit = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
	assign d        = is_digit ? char_s1[3:0] : 4'd0;
	assign d2       = {d, 1'b0};
	assign dbl      = (d2 > 5'd9) ? 4'(d2 - 5'd9) : d2[3:0];
	assign w        = weight_at(scheme_q, count_q);
	assign prod     = d * w;

	always_comb begin
		even_term = count_q[0] ? d : dbl;
		odd_term  = count_q[0] ? dbl : d;
		even_tot  = {1'b0, even_tot_q} + TOT_W'(even_term);
		odd_tot   = {1'b0, odd_tot_q} + TOT_W'(odd_term);
		wsum_tot  = {1'b0, wsum_q} + TOT_W'(prod);
		even_nx   = add_mod(add_mod(even_q, even_term, 4'd10),
			even_tot[SUM_W] ? WRAP10 : 4'd0, 4'd10);
		odd_nx    = add_mod(add_mod(odd_q, odd_term, 4'd10),
			odd_tot[SUM_W] ? WRAP10 : 4'd0, 4'd10);
		w9_nx     = add_mod(add_mod(w9_q, MOD9_LUT[prod[PROD_W-1:0]], 4'd9),
			wsum_tot[SUM_W] ? WRAP9 : 4'd0, 4'd9);
		w10_nx    = add_mod(add_mod(w10_q, MOD10_LUT[prod[PROD_W-1:0]], 4'd10),
			wsum_tot[SUM_W] ? WRAP10 : 4'd0, 4'd10);
		w11_nx    = add_mod(add_mod(w11_q, MOD11_LUT[prod[PROD_W-1:0]], 4'd11),
			wsum_tot[SUM_W] ? WRAP11 : 4'd0, 4'd11);
	end

	// Check value and verdict for a last character.
	always_comb begin
		luhn_r  = count_q[0] ? even_q : odd_q;
		luhn_cv = (count_q == '0 || luhn_r == '0) ? 4'd0 : 4'd10 - luhn_r;
		len     = {1'b0, count_q} + LEN_W'(1);
		check   = 4'd0;
		len_ok  = 1'b0;
		unique case (scheme_q)
			SCH_LUHN: begin
				check  = luhn_cv;
				len_ok = (len <= LEN_MAX);
			end
			SCH_IMEI: begin
				check  = luhn_cv;
				len_ok = (len == LEN_IMEI);
			end
			SCH_USPS: begin
				check  = w9_q;
				len_ok = (len == LEN_USPS);
			end
			SCH_UPC: begin
				check  = (w10_q == '0) ? 4'd0 : 4'd10 - w10_q;
				len_ok = (len == LEN_UPC);
			end
			SCH_ISBN10: begin
				check  = w11_q;
				len_ok = (len == LEN_ISBN10);
			end
			SCH_ISBN13: begin
				check  = (w10_q == '0) ? 4'd0 : 4'd10 - w10_q;
				len_ok = (len == LEN_ISBN13);
			end
			SCH_ROUTING: begin
				check  = w10_q;
				len_ok = (len == LEN_ROUTING);
			end
			SCH_ISSN: begin
				check  = (w11_q == '0) ? 4'd0 : 4'd11 - w11_q;
				len_ok = (len == LEN_ISSN);
			end
			default: begin
				check  = 4'd0;
				len_ok = 1'b0;
			end
		endcase

		xok   = (scheme_q == SCH_ISBN10 || scheme_q == SCH_ISSN)
			&& (char_s1 == CHAR_X_UPPER || char_s1 == CHAR_X_LOWER);
		given = is_digit ? d : CHECK_X;

		status_nx = ST_BAD_CHAR;
		value_nx  = 4'd0;
		priority if (!len_ok) begin
			status_nx = ST_BAD_LENGTH;
		end else if (bad_q) begin
			status_nx = ST_BAD_CHAR;
		end else if (char_s1 == CHAR_STAR) begin
			status_nx = ST_CHECK_VALUE;
			value_nx  = check;
		end else if (is_digit || xok) begin
			status_nx = (given == check) ? ST_VERIFIED : ST_NOT_VERIFIED;
			value_nx  = check;
		end else begin
			status_nx = ST_BAD_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			even_q     <= '0;
			odd_q      <= '0;
			w9_q       <= '0;
			w10_q      <= '0;
			w11_q      <= '0;
			even_tot_q <= '0;
			odd_tot_q  <= '0;
			wsum_q     <= '0;
			bad_q      <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				count_q    <= '0;
				even_q     <= '0;
				odd_q      <= '0;
				w9_q       <= '0;
				w10_q      <= '0;
				w11_q      <= '0;
				even_tot_q <= '0;
				odd_tot_q  <= '0;
				wsum_q     <= '0;
				bad_q      <= 1'b0;
			end else begin
				if (count_q != COUNT_SAT) begin
					count_q <= count_q + COUNT_W'(1);
				end
				if (is_digit) begin
					even_q     <= even_nx;
					odd_q      <= odd_nx;
					w9_q       <= w9_nx;
					w10_q      <= w10_nx;
					w11_q      <= w11_nx;
					even_tot_q <= even_tot[SUM_W-1:0];
					odd_tot_q  <= odd_tot[SUM_W-1:0];
					wsum_q     <= wsum_tot[SUM_W-1:0];
				end else begin
					bad_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			status_q <= status_nx;
			check_q  <= value_nx;
		end
	end

	assign verdict.valid       = out_valid_q;
	assign verdict.status      = status_q;
	assign verdict.check_value = check_q;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && last_s1 |=> out_valid_q)
		else $error("A last character did not load a result.");

	a_last_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && last_s1 |=> count_q == '0 && !bad_q)
		else $error("Running state not cleared after a last character.");

	a_stall_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!digits.ready |-> valid_s1 && last_s1 && out_valid_q && !verdict.ready)
		else $error("Input stalled without a waiting result.");

	a_error_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_BAD_LENGTH || status_q == ST_BAD_CHAR)
			|-> check_q == '0)
		else $error("Nonzero check value with a length or character error.");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> check_q <= CHECK_X)
		else $error("Check value out of range.");

endmodule
